>>> src/sbusfd_pkg.sv
`timescale 1ns / 1ps

package sbusfd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CHAN_W     = 11;
    localparam int unsigned NUM_CHANS  = 8;
    localparam int unsigned NUM_CELLS  = 23;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned LINK_W     = 2;

    localparam logic [BYTE_W-1:0] SBUS_HEADER = 8'h0F;
    localparam logic [BYTE_W-1:0] SBUS_FOOTER = 8'h00;
    localparam logic [POS_W-1:0]  LAST_POS    = 5'd24;

    localparam int unsigned LOST_BIT     = 2;
    localparam int unsigned FAILSAFE_BIT = 3;

    localparam logic [LINK_W-1:0] LINK_OK       = 2'd0;
    localparam logic [LINK_W-1:0] LINK_LOST     = 2'd1;
    localparam logic [LINK_W-1:0] LINK_FAILSAFE = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [LINK_W-1:0] t_link;

    // status byte to link code, failsafe wins over lost
    function automatic t_link link_code(input t_byte st);
        t_link code;
        if (st[FAILSAFE_BIT]) begin
            code = LINK_FAILSAFE;
        end else if (st[LOST_BIT]) begin
            code = LINK_LOST;
        end else begin
            code = LINK_OK;
        end
        return code;
    endfunction

endpackage

>>> src/sbusfd_if.sv
`timescale 1ns / 1ps

interface sbusfd_in_if;
    logic                      valid;
    logic                      ready;
    logic [sbusfd_pkg::BYTE_W-1:0] rx_byte;
    logic                      burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface sbusfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_one;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_two;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_three;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_four;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_five;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_six;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_seven;
    logic [sbusfd_pkg::CHAN_W-1:0] chan_eight;
    logic [sbusfd_pkg::LINK_W-1:0] link_status;

    modport source (output valid, input ready,
                    output chan_one, output chan_two, output chan_three, output chan_four,
                    output chan_five, output chan_six, output chan_seven, output chan_eight,
                    output link_status);
    modport sink   (input valid, output ready,
                    input chan_one, input chan_two, input chan_three, input chan_four,
                    input chan_five, input chan_six, input chan_seven, input chan_eight,
                    input link_status);
endinterface

>>> src/sbusfd_cell.sv
`timescale 1ns / 1ps

module sbusfd_cell (
    input  logic               i_clk,
    input  logic               i_shift,
    input  sbusfd_pkg::t_byte  i_byte,
    output sbusfd_pkg::t_byte  o_byte
);
    import sbusfd_pkg::*;

    t_byte r_byte;

    // one frame byte, moves one place down the row per stored beat
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

>>> src/sbus_frame_decoder_top.sv
`timescale 1ns / 1ps

// channel   dir  payload                               handshake
// i_rx      in   rx_byte[8], burst_end[1]              valid / ready
// o_frame   out  chan_one..chan_eight[11], link_status[2]  valid / ready
//
// one input beat per cycle while ready; o_frame is valid the cycle after the end byte
// ready stays high while a result waits, unless that result is not taken this cycle
// i_rst_n (synchronous, active low) returns the block to hunting and drops a pending result
// the frame store is a row of 23 byte cells with no reset: every cell is refilled per frame

module sbus_frame_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbusfd_in_if.sink   i_rx,
    sbusfd_out_if.source o_frame
);
    import sbusfd_pkg::*;

    // control state
    logic               r_in_frame;
    logic [POS_W-1:0]   r_byte_pos;
    logic               r_out_valid;

    // result registers
    t_chan              r_chan [NUM_CHANS];
    t_link              r_link;

    logic               in_beat;
    logic               out_beat;
    logic [POS_W-1:0]   n_byte_pos;
    logic               store_beat;
    logic               emit;

    // row of cells: cell 0 holds the newest byte, cell 22 frame byte 1
    t_byte              cell_q [NUM_CELLS];
    logic [NUM_CELLS*BYTE_W-1:0] frame_flat;
    t_chan              chan_w [NUM_CHANS];

    assign out_beat   = r_out_valid && o_frame.ready;
    assign i_rx.ready = !r_out_valid || o_frame.ready;
    assign in_beat    = i_rx.valid && i_rx.ready;

    assign n_byte_pos = r_byte_pos + 5'd1;
    // data bytes 1..23 go into the row, the end byte does not
    assign store_beat = in_beat && r_in_frame && (n_byte_pos < LAST_POS);
    assign emit       = in_beat && r_in_frame && (n_byte_pos == LAST_POS)
                        && (i_rx.rx_byte == SBUS_FOOTER);

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_head
            sbusfd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (store_beat),
                .i_byte  (i_rx.rx_byte),
                .o_byte  (cell_q[g])
            );
        end else begin : g_body
            sbusfd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (store_beat),
                .i_byte  (cell_q[g-1]),
                .o_byte  (cell_q[g])
            );
        end
        // little-endian bit stream, frame byte 1 first
        assign frame_flat[g*BYTE_W +: BYTE_W] = cell_q[NUM_CELLS-1-g];
    end

    // channels are fixed slices of the bit stream
    for (genvar k = 0; k < NUM_CHANS; k++) begin : g_chan
        assign chan_w[k] = frame_flat[k*CHAN_W +: CHAN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_byte_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                if (!r_in_frame) begin
                    // hunting: a header that ends its burst cannot start a frame
                    if (i_rx.rx_byte == SBUS_HEADER && !i_rx.burst_end) begin
                        r_in_frame <= 1'b1;
                        r_byte_pos <= '0;
                    end
                end else begin
                    r_byte_pos <= n_byte_pos;
                    if (n_byte_pos < LAST_POS) begin
                        // burst ended early, drop the frame
                        if (i_rx.burst_end) begin
                            r_in_frame <= 1'b0;
                        end
                    end else begin
                        // end byte: back to hunting whether good or bad
                        r_in_frame <= 1'b0;
                    end
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only on a good end byte
    always_ff @(posedge i_clk) begin
        if (emit) begin
            for (int k = 0; k < NUM_CHANS; k++) begin
                r_chan[k] <= chan_w[k];
            end
            r_link <= link_code(cell_q[0]);
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.chan_one    = r_chan[0];
    assign o_frame.chan_two    = r_chan[1];
    assign o_frame.chan_three  = r_chan[2];
    assign o_frame.chan_four   = r_chan[3];
    assign o_frame.chan_five   = r_chan[4];
    assign o_frame.chan_six    = r_chan[5];
    assign o_frame.chan_seven  = r_chan[6];
    assign o_frame.chan_eight  = r_chan[7];
    assign o_frame.link_status = r_link;

endmodule
